// ----- rtl/core/two_key_priority_queue_unit_assert.svh -----
// Assertion macros for the two-key priority queue unit.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef TWO_KEY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define TWO_KEY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TKPQ_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("tkpq check failed");
`define TKPQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("tkpq check failed");
`else
`define TKPQ_ASSERT_SAME(label, pre, post)
`define TKPQ_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/core/tkpq_pkg.sv -----
// Shared types, codes and the key compare for the two-key priority queue.
// No dependencies.
package tkpq_pkg;

    localparam int TAG_W   = 32;
    localparam int SCORE_W = 7;
    localparam int OCC_W   = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] prim;
        logic [SCORE_W-1:0] sec;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

    typedef struct packed {
        logic               item_valid;
        logic [TAG_W-1:0]   item_tag;
        logic [SCORE_W-1:0] item_primary;
        logic [SCORE_W-1:0] item_secondary;
        logic               refused;
        logic               now_empty;
        logic               now_full;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

    // stored entry ranks strictly below the key pair (p, q)
    function automatic logic ranks_below(t_entry s, logic [SCORE_W-1:0] p,
                                         logic [SCORE_W-1:0] q);
        return {s.prim, s.sec} < {p, q};
    endfunction

endpackage

// ----- rtl/core/tkpq_in_if.sv -----
// Command channel of the two-key priority queue: valid/ready plus command fields.
// Depends on tkpq_pkg for field widths.
interface tkpq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [tkpq_pkg::TAG_W-1:0]        entry_tag;
    logic [tkpq_pkg::SCORE_W-1:0]      primary_score;
    logic [tkpq_pkg::SCORE_W-1:0]      secondary_score;

    modport source (output valid, operation, entry_tag, primary_score, secondary_score,
                    input ready);
    modport sink   (input valid, operation, entry_tag, primary_score, secondary_score,
                    output ready);
endinterface

// ----- rtl/core/tkpq_out_if.sv -----
// Result channel of the two-key priority queue: valid/ready plus result fields.
// Depends on tkpq_pkg for field widths.
interface tkpq_out_if;
    logic                              valid;
    logic                              ready;
    logic                              item_valid;
    logic [tkpq_pkg::TAG_W-1:0]        item_tag;
    logic [tkpq_pkg::SCORE_W-1:0]      item_primary;
    logic [tkpq_pkg::SCORE_W-1:0]      item_secondary;
    logic                              refused;
    logic                              now_empty;
    logic                              now_full;
    logic [tkpq_pkg::OCC_W-1:0]        occupancy;

    modport source (output valid, item_valid, item_tag, item_primary, item_secondary,
                    refused, now_empty, now_full, occupancy, input ready);
    modport sink   (input valid, item_valid, item_tag, item_primary, item_secondary,
                    refused, now_empty, now_full, occupancy, output ready);
endinterface

// ----- rtl/core/tkpq_cell.sv -----
// One slot of the sorted chain: holds an entry, compares it with the new key
// and shifts with its neighbours. Depends on tkpq_pkg.
module tkpq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                 i_clk,
    input  tkpq_pkg::t_cell_ctrl i_ctrl,
    input  tkpq_pkg::t_entry     i_new,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_left_ins,
    input  tkpq_pkg::t_entry     i_left_entry,
    input  tkpq_pkg::t_entry     i_right_entry,
    output logic                 o_ins,
    output tkpq_pkg::t_entry     o_entry
);

    tkpq_pkg::t_entry r_entry;
    tkpq_pkg::t_entry n_entry;
    logic             occupied;

    assign occupied = i_count > CNT_W'(IDX);
    // empty slots count as below, so the flag is a thermometer along the chain
    assign o_ins    = !occupied || tkpq_pkg::ranks_below(r_entry, i_new.prim, i_new.sec);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq && o_ins) begin
            n_entry = i_left_ins ? i_left_entry : i_new;
        end else if (i_ctrl.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/core/two_key_priority_queue_unit.sv -----
// Two-key priority queue: a chain of sorted cells, highest (primary, secondary) first.
// Depends on tkpq_pkg, tkpq_in_if, tkpq_out_if, tkpq_cell and the assert header.
//
// Usage: i_cmd carries one command per transaction, enqueue (tag and two scores)
// or dequeue. o_res returns exactly one result transaction per command: the
// removed head on a dequeue, a refusal flag for an enqueue into a full queue,
// and empty/full/occupancy after the step. Equal keys leave in arrival order.
// The result is registered and shows in the cycle after the command is
// taken. Throughput: one command per cycle unless a stall holds i_cmd.ready low;
// every cell compares the new key with its own entry and shifts to its neighbour
// in the same cycle, so the chain length does not set the rate.
// Reset: synchronous, active low; the queue is empty and no result is pending.
// Entry storage needs no clearing, the fill count marks which cells hold data.
// Stall: while a result waits and o_res.ready is low, i_cmd.ready is low and
// the queue holds its contents; the result is kept until taken.
`include "two_key_priority_queue_unit_assert.svh"
module two_key_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tkpq_in_if.sink           i_cmd,
    tkpq_out_if.source        o_res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    tkpq_pkg::t_result    r_res;
    tkpq_pkg::t_result    n_res;
    tkpq_pkg::t_cell_ctrl ctrl;
    tkpq_pkg::t_entry     new_entry;
    tkpq_pkg::t_entry     cell_entry [QUEUE_DEPTH];
    logic                 cell_ins   [QUEUE_DEPTH];
    logic                 cmd_fire;
    logic                 is_full;
    logic                 is_empty;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign is_full     = r_count == CNT_W'(QUEUE_DEPTH);
    assign is_empty    = r_count == '0;

    assign new_entry.tag  = i_cmd.entry_tag;
    assign new_entry.prim = i_cmd.primary_score;
    assign new_entry.sec  = i_cmd.secondary_score;

    assign ctrl.enq = cmd_fire && (i_cmd.operation == tkpq_pkg::OP_ENQ) && !is_full;
    assign ctrl.deq = cmd_fire && (i_cmd.operation == tkpq_pkg::OP_DEQ) && !is_empty;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic             left_ins;
            tkpq_pkg::t_entry left_entry;
            tkpq_pkg::t_entry right_entry;
            if (gi == 0) begin : g_head
                assign left_ins   = 1'b0;
                assign left_entry = '0;
            end else begin : g_mid
                assign left_ins   = cell_ins[gi-1];
                assign left_entry = cell_entry[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign right_entry = '0;
            end else begin : g_body
                assign right_entry = cell_entry[gi+1];
            end
            tkpq_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (ctrl),
                .i_new         (new_entry),
                .i_count       (r_count),
                .i_left_ins    (left_ins),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .o_ins         (cell_ins[gi]),
                .o_entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctrl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.deq) begin
            n_count = r_count - CNT_W'(1);
        end
        n_res                = '0;
        n_res.item_valid     = ctrl.deq;
        if (ctrl.deq) begin
            n_res.item_tag       = cell_entry[0].tag;
            n_res.item_primary   = cell_entry[0].prim;
            n_res.item_secondary = cell_entry[0].sec;
        end
        n_res.refused   = (i_cmd.operation == tkpq_pkg::OP_ENQ) && is_full;
        n_res.now_empty = n_count == '0;
        n_res.now_full  = n_count == CNT_W'(QUEUE_DEPTH);
        n_res.occupancy = tkpq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (cmd_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.item_valid     = r_res.item_valid;
    assign o_res.item_tag       = r_res.item_tag;
    assign o_res.item_primary   = r_res.item_primary;
    assign o_res.item_secondary = r_res.item_secondary;
    assign o_res.refused        = r_res.refused;
    assign o_res.now_empty      = r_res.now_empty;
    assign o_res.now_full       = r_res.now_full;
    assign o_res.occupancy      = r_res.occupancy;

    `TKPQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `TKPQ_ASSERT_NEXT(a_enq_grows, ctrl.enq, r_count == $past(r_count) + CNT_W'(1))
    `TKPQ_ASSERT_SAME(a_refuse_full, r_out_valid && r_res.refused, r_res.now_full)
    `TKPQ_ASSERT_NEXT(a_stall_holds, r_out_valid && !o_res.ready, r_count == $past(r_count))

endmodule

// ----- bench/two_key_priority_queue_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for two_key_priority_queue_unit: directed and random enqueue/dequeue traffic
// checked against an in-bench sorted shadow of the queue contents.
// Depends on tkpq_pkg, tkpq_in_if, tkpq_out_if and the unit itself.
module two_key_priority_queue_unit_test;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;

    tkpq_in_if  cmd_if ();
    tkpq_out_if res_if ();

    two_key_priority_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // shadow of the queue, kept sorted highest key pair first
    tkpq_pkg::t_entry  shadow_slots [DEPTH];
    int                shadow_count;
    tkpq_pkg::t_result awaited_results [$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one queue operation on the shadow; returns the result it should produce
    function automatic tkpq_pkg::t_result apply_queue_op(logic op,
                                                         logic [tkpq_pkg::TAG_W-1:0] tag,
                                                         logic [tkpq_pkg::SCORE_W-1:0] p,
                                                         logic [tkpq_pkg::SCORE_W-1:0] q);
        tkpq_pkg::t_result r;
        int                pos;
        bit                found;
        r = '0;
        if (op == tkpq_pkg::OP_ENQ) begin
            if (shadow_count >= DEPTH) begin
                r.refused = 1'b1;
            end else begin
                pos   = shadow_count;
                found = 1'b0;
                // new entry goes behind every stored entry with an equal or greater pair
                for (int i = 0; i < shadow_count; i++) begin
                    if (!found && (shadow_slots[i].prim < p ||
                                   (shadow_slots[i].prim == p && shadow_slots[i].sec < q))) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = shadow_count; i > pos; i--)
                    shadow_slots[i] = shadow_slots[i-1];
                shadow_slots[pos].tag  = tag;
                shadow_slots[pos].prim = p;
                shadow_slots[pos].sec  = q;
                shadow_count++;
            end
        end else if (shadow_count > 0) begin
            r.item_valid     = 1'b1;
            r.item_tag       = shadow_slots[0].tag;
            r.item_primary   = shadow_slots[0].prim;
            r.item_secondary = shadow_slots[0].sec;
            for (int i = 1; i < shadow_count; i++)
                shadow_slots[i-1] = shadow_slots[i];
            shadow_count--;
        end
        r.now_empty = (shadow_count == 0);
        r.now_full  = (shadow_count >= DEPTH);
        r.occupancy = shadow_count[tkpq_pkg::OCC_W-1:0];
        return r;
    endfunction

    // scores bunched near zero often, to force ties on one or both keys
    function automatic logic [tkpq_pkg::SCORE_W-1:0] rand_score();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return tkpq_pkg::SCORE_W'($urandom_range(0, 3));
        else if (pick < 50)
            return $urandom_range(0, 1) ? {tkpq_pkg::SCORE_W{1'b1}} : '0;
        else
            return tkpq_pkg::SCORE_W'($urandom_range(0, 127));
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // offer one command and wait for the transaction; valid stays high afterwards
    task automatic send_cmd(logic op, logic [tkpq_pkg::TAG_W-1:0] tag,
                            logic [tkpq_pkg::SCORE_W-1:0] p,
                            logic [tkpq_pkg::SCORE_W-1:0] q);
        // each idle cycle drawn on its own, so the idle share matches the percentage
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid           <= 1'b1;
        cmd_if.operation       <= op;
        cmd_if.entry_tag       <= tag;
        cmd_if.primary_score   <= p;
        cmd_if.secondary_score <= q;
        do @(posedge i_clk); while (!cmd_if.ready);
        awaited_results.push_back(apply_queue_op(op, tag, p, q));
    endtask

    task automatic send_deq();
        // payload is don't-care on a dequeue; keep it moving
        send_cmd(tkpq_pkg::OP_DEQ, $urandom, rand_score(), rand_score());
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic test_directed_extremes();
        send_deq();                                   // dequeue on an empty queue
        send_cmd(tkpq_pkg::OP_ENQ, 32'h0000_0000, 7'd0,   7'd0);
        send_cmd(tkpq_pkg::OP_ENQ, 32'hFFFF_FFFF, 7'd127, 7'd127);
        send_cmd(tkpq_pkg::OP_ENQ, 32'hA5A5_5A5A, 7'd127, 7'd0);
        send_cmd(tkpq_pkg::OP_ENQ, 32'h5A5A_A5A5, 7'd0,   7'd127);
        // equal pairs must leave in arrival order
        send_cmd(tkpq_pkg::OP_ENQ, 32'h1111_1111, 7'd64,  7'd64);
        send_cmd(tkpq_pkg::OP_ENQ, 32'h2222_2222, 7'd64,  7'd64);
        repeat (7) send_deq();                        // last one finds it empty again
        settle();
    endtask

    task automatic test_full_refusal();
        repeat (DEPTH) send_cmd(tkpq_pkg::OP_ENQ, $urandom, rand_score(), rand_score());
        // top and bottom keys both bounce off a full queue
        send_cmd(tkpq_pkg::OP_ENQ, 32'hFFFF_FFFF, 7'd127, 7'd127);
        send_cmd(tkpq_pkg::OP_ENQ, 32'h0000_0000, 7'd0,   7'd0);
        repeat (DEPTH + 1) send_deq();
        settle();
    endtask

    task automatic test_receiver_hold();
        // result side stops for a long stretch while commands keep coming
        hold_left = HOLD_CYCLES;
        repeat (20) send_cmd(tkpq_pkg::OP_ENQ, $urandom, rand_score(), rand_score());
        repeat (4) send_deq();
        settle();
    endtask

    task automatic test_random_traffic(int n_items);
        int sent;
        int burst;
        int enq_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            repeat (burst) begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_cmd(tkpq_pkg::OP_ENQ, $urandom, rand_score(), rand_score());
                else
                    send_deq();
                sent++;
            end
        end
        settle();
    endtask

    // result side ready, with optional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        tkpq_pkg::t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no command outstanding",
                                32'(res_if.occupancy), 32'd0);
            end else begin
                want = awaited_results.pop_front();
                check_field("item_valid",     32'(res_if.item_valid),
                            32'(want.item_valid));
                check_field("item_tag",       res_if.item_tag, want.item_tag);
                check_field("item_primary",   32'(res_if.item_primary),
                            32'(want.item_primary));
                check_field("item_secondary", 32'(res_if.item_secondary),
                            32'(want.item_secondary));
                check_field("refused",        32'(res_if.refused), 32'(want.refused));
                check_field("now_empty",      32'(res_if.now_empty), 32'(want.now_empty));
                check_field("now_full",       32'(res_if.now_full), 32'(want.now_full));
                check_field("occupancy",      32'(res_if.occupancy), 32'(want.occupancy));
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("two_key_priority_queue_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.operation       = tkpq_pkg::OP_ENQ;
        cmd_if.entry_tag       = '0;
        cmd_if.primary_score   = '0;
        cmd_if.secondary_score = '0;
        res_if.ready           = 1'b0;
        shadow_count           = 0;
        error_count            = 0;
        hold_left              = 0;
        quiet_cycles           = 0;
        send_idle_pct          = 21;
        recv_idle_pct          = 51;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_full_refusal();
        test_random_traffic(160);

        send_idle_pct = 51;
        recv_idle_pct = 21;
        test_receiver_hold();
        test_random_traffic(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(160);

        settle();
        repeat (8) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", 32'd0,
                            32'(awaited_results.size()));

        if (error_count == 0) begin
            $display("two_key_priority_queue_unit_test: PASS");
        end else begin
            $display("two_key_priority_queue_unit_test: FAIL");
        end
        $finish;
    end

endmodule
